FILE: sv/ncg_pkg.sv
// Shared types and constants for the nearest code gradient colour block.
`timescale 1ns / 1ps

package ncg_pkg;

  localparam int CODE_W     = 32;
  localparam int CODE_DIGITS = 16;
  localparam int DEPTH_W    = 5;
  localparam int COLOR_W    = 8;
  localparam int PROD_W     = DEPTH_W + COLOR_W;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_DEPTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_RED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_GREEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_BLUE    = 3'd6;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT
  } ncg_state_t;

endpackage

FILE: sv/ncg_store.sv
// Code store: single write port, one registered read port.
`timescale 1ns / 1ps

module ncg_store #(
  parameter int ENTRIES = 1024,
  parameter int ADDR_W  = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [ncg_pkg::CODE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [ncg_pkg::CODE_W-1:0] rdata
);

  logic [ncg_pkg::CODE_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ncg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the colour channels.
`timescale 1ns / 1ps

module ncg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ncg_pkg::PROD_W-1:0]  dividend,
  input  logic [ncg_pkg::DEPTH_W-1:0] divisor,
  output logic                        done,
  output logic [ncg_pkg::PROD_W-1:0]  quot
);

  localparam int CNT_W = $clog2(ncg_pkg::PROD_W + 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [ncg_pkg::DEPTH_W-1:0] rem;
  logic [ncg_pkg::DEPTH_W:0]   shifted;
  logic [ncg_pkg::DEPTH_W:0]   trial;
  logic                        ge;
  logic [ncg_pkg::DEPTH_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quot[ncg_pkg::PROD_W-1]};
    trial    = shifted - {1'b0, divisor};
    ge       = shifted >= {1'b0, divisor};
    rem_next = ge ? trial[ncg_pkg::DEPTH_W-1:0] : shifted[ncg_pkg::DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ncg_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[ncg_pkg::PROD_W-2:0], ge};
    end
  end

endmodule

FILE: sv/nearest_code_gradient_colour.sv
// Top level: code store, nearest code search and gradient colour sequencer.
//
// Usage: an item (mode, path_code) is taken at a clock edge with start high
// and busy low. Mode 0 clears the stored set in that cycle and gives no
// result. Mode 1 appends path_code; its result follows in the next cycle with
// store_overflow high if the set was full. Mode 2 queries path_code: the
// stored codes are read one per cycle from the store memory, and each colour
// channel then passes through the shared 13-step divider; an exact match ends
// the scan early. Mode 3 is ignored. busy stays high for the whole query.
// Each result is shown for one cycle with done high; the receiver cannot
// stall, so nothing waits. Registers are written through cfg_we, cfg_addr
// and cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce. Reset empties the set and
// restores depth 10, start colour black and end colour white; store contents
// stay undefined until written.
`timescale 1ns / 1ps

module nearest_code_gradient_colour #(
  parameter int MAX_DIGITS    = 16,
  parameter int STORE_ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ncg_pkg::MODE_W-1:0]     mode,
  input  logic [ncg_pkg::CODE_W-1:0]     path_code,
  output logic                           done,
  output logic [ncg_pkg::DEPTH_W-1:0]    digit_distance,
  output logic [ncg_pkg::COLOR_W-1:0]    red_out,
  output logic [ncg_pkg::COLOR_W-1:0]    green_out,
  output logic [ncg_pkg::COLOR_W-1:0]    blue_out,
  output logic                           store_overflow,
  input  logic                           cfg_we,
  input  logic [ncg_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ncg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(STORE_ENTRIES + 1);
  localparam int ADDR_W = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
  localparam int DW     = ncg_pkg::DEPTH_W;
  localparam int CW     = ncg_pkg::COLOR_W;
  localparam int PW     = ncg_pkg::PROD_W;

  ncg_pkg::ncg_state_t state, state_next;

  logic [DW-1:0] code_depth;
  logic [CW-1:0] start_red, start_green, start_blue;
  logic [CW-1:0] end_red, end_green, end_blue;

  logic [CNT_W-1:0]           match_count;
  logic [CNT_W-1:0]           issue_idx;
  logic                       pend;
  logic [ncg_pkg::CODE_W-1:0] query_code;
  logic [DW-1:0]              depth;
  logic [DW-1:0]              best;
  logic [1:0]                 chan;
  logic [ncg_pkg::PROD_W-1:0] prod;

  logic                       accept;
  logic                       store_we;
  logic                       store_full;
  logic [ncg_pkg::CODE_W-1:0] rdata;
  logic                       issue;
  logic [DW-1:0]              dist_cur;
  logic [DW-1:0]              best_next;
  logic                       scan_end;
  logic [DW-1:0]              depth_eff;
  logic [CW-1:0]              ch_s, ch_e, ch_lo, ch_diff;
  logic [DW-1:0]              ch_k;
  logic [ncg_pkg::PROD_W-1:0] quot;
  logic [CW-1:0]              ch_val;
  logic                       div_start;
  logic                       div_done;

  assign busy       = state != ncg_pkg::ST_IDLE;
  assign accept     = start && !busy;
  assign store_full = match_count >= CNT_W'(STORE_ENTRIES);
  assign store_we   = accept && mode == ncg_pkg::MODE_LOAD && !store_full;
  assign issue      = issue_idx < match_count;

  ncg_store #(
    .ENTRIES (STORE_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (match_count[ADDR_W-1:0]),
    .wdata (path_code),
    .raddr (issue_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  ncg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (depth),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    depth_eff = code_depth;
    if (code_depth == '0) begin
      depth_eff = DW'(1);
    end else if (32'(code_depth) > MAX_DIGITS) begin
      depth_eff = DW'(MAX_DIGITS);
    end
  end

  always_comb begin
    dist_cur = '0;
    for (int i = 0; i < ncg_pkg::CODE_DIGITS; i++) begin
      if (32'(i) < 32'(depth) && (rdata[2*i +: 2] != query_code[2*i +: 2])) begin
        dist_cur = dist_cur + DW'(1);
      end
    end
    best_next = (pend && dist_cur < best) ? dist_cur : best;
    scan_end  = (best_next == '0) || (!issue && !pend);
  end

  always_comb begin
    unique case (chan)
      2'd0: begin
        ch_s = start_red;
        ch_e = end_red;
      end
      2'd1: begin
        ch_s = start_green;
        ch_e = end_green;
      end
      default: begin
        ch_s = start_blue;
        ch_e = end_blue;
      end
    endcase
    ch_lo   = (ch_s < ch_e) ? ch_s : ch_e;
    ch_diff = (ch_s < ch_e) ? ch_e - ch_s : ch_s - ch_e;
    ch_k    = (ch_e > ch_s) ? depth - best : best;
    ch_val  = CW'(quot) + ch_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ncg_pkg::ST_IDLE: begin
        if (accept && mode == ncg_pkg::MODE_QUERY) begin
          state_next = ncg_pkg::ST_SCAN;
        end
      end
      ncg_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = ncg_pkg::ST_MUL;
        end
      end
      ncg_pkg::ST_MUL: begin
        state_next = ncg_pkg::ST_DIV_GO;
      end
      ncg_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ncg_pkg::ST_DIV_WAIT;
      end
      ncg_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (chan == 2'd2) ? ncg_pkg::ST_IDLE : ncg_pkg::ST_MUL;
        end
      end
      default: begin
        state_next = ncg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_depth  <= ncg_pkg::DEPTH_RESET;
      start_red   <= '0;
      start_green <= '0;
      start_blue  <= '0;
      end_red     <= '1;
      end_green   <= '1;
      end_blue    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ncg_pkg::REG_CODE_DEPTH:  code_depth  <= cfg_wdata[DW-1:0];
        ncg_pkg::REG_START_RED:   start_red   <= cfg_wdata;
        ncg_pkg::REG_START_GREEN: start_green <= cfg_wdata;
        ncg_pkg::REG_START_BLUE:  start_blue  <= cfg_wdata;
        ncg_pkg::REG_END_RED:     end_red     <= cfg_wdata;
        ncg_pkg::REG_END_GREEN:   end_green   <= cfg_wdata;
        ncg_pkg::REG_END_BLUE:    end_blue    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
      done        <= 1'b0;
      pend        <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      if (accept && mode == ncg_pkg::MODE_CLEAR) begin
        match_count <= '0;
      end
      if (store_we) begin
        match_count <= match_count + CNT_W'(1);
      end
      if (accept && mode == ncg_pkg::MODE_LOAD) begin
        done <= 1'b1;
      end
      if (state == ncg_pkg::ST_SCAN) begin
        pend <= issue && !scan_end;
      end
      if (state == ncg_pkg::ST_DIV_WAIT && div_done && chan == 2'd2) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == ncg_pkg::MODE_LOAD) begin
      digit_distance <= '0;
      red_out        <= '0;
      green_out      <= '0;
      blue_out       <= '0;
      store_overflow <= store_full;
    end
    if (accept && mode == ncg_pkg::MODE_QUERY) begin
      query_code <= path_code;
      depth      <= depth_eff;
      best       <= depth_eff;
      issue_idx  <= '0;
      chan       <= 2'd0;
    end
    if (state == ncg_pkg::ST_SCAN) begin
      best <= best_next;
      if (issue) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
    end
    if (state == ncg_pkg::ST_MUL) begin
      prod <= PW'(ch_k) * PW'(ch_diff);
    end
    if (state == ncg_pkg::ST_DIV_WAIT && div_done) begin
      chan <= chan + 2'd1;
      unique case (chan)
        2'd0: red_out <= ch_val;
        2'd1: green_out <= ch_val;
        default: begin
          blue_out       <= ch_val;
          digit_distance <= best;
          store_overflow <= 1'b0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    match_count <= CNT_W'(STORE_ENTRIES))
    else $error("stored code count above capacity");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    done && store_overflow |-> digit_distance == '0 && red_out == '0)
    else $error("overflow word carries nonzero fields");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && mode == ncg_pkg::MODE_QUERY |=> busy && !done)
    else $error("query did not hold busy");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    state == ncg_pkg::ST_DIV_WAIT |-> best <= depth)
    else $error("distance above depth");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the nearest code gradient colour block.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_DIGITS    = 16;
  localparam int STORE_ENTRIES = 1024;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 80;
  localparam int FINAL_LOADS   = 20;
  localparam int IDLE_LIMIT    = 20000;
  localparam int DW            = ncg_pkg::DEPTH_W;
  localparam int CW            = ncg_pkg::COLOR_W;
  localparam int MW            = ncg_pkg::MODE_W;
  localparam int KW            = ncg_pkg::CODE_W;
  localparam int IW            = ncg_pkg::CFG_IDX_W;
  localparam int VW            = ncg_pkg::CFG_DATA_W;

  localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [DW-1:0] ndiff;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          ovf;
  } gradient_word_t;

  class gradient_scoreboard;
    logic [KW-1:0]  codes[$];
    logic [DW-1:0]  depth_reg;
    logic [CW-1:0]  start_rgb[3];
    logic [CW-1:0]  end_rgb[3];
    gradient_word_t want_q[$];
    int             errors;

    function new();
      depth_reg = ncg_pkg::DEPTH_RESET;
      foreach (start_rgb[i]) begin
        start_rgb[i] = '0;
        end_rgb[i]   = 8'hFF;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
      unique case (idx)
        ncg_pkg::REG_CODE_DEPTH:  depth_reg = val[DW-1:0];
        ncg_pkg::REG_START_RED:   start_rgb[0] = val;
        ncg_pkg::REG_START_GREEN: start_rgb[1] = val;
        ncg_pkg::REG_START_BLUE:  start_rgb[2] = val;
        ncg_pkg::REG_END_RED:     end_rgb[0] = val;
        ncg_pkg::REG_END_GREEN:   end_rgb[1] = val;
        ncg_pkg::REG_END_BLUE:    end_rgb[2] = val;
        default: ;
      endcase
    endfunction

    function int shade(logic [CW-1:0] s, logic [CW-1:0] e, int nd, int d);
      int s_i, e_i, lo, span, k;
      s_i  = int'(s);
      e_i  = int'(e);
      lo   = (s_i < e_i) ? s_i : e_i;
      span = (s_i < e_i) ? e_i - s_i : s_i - e_i;
      k    = (e_i > s_i) ? d - nd : nd;
      return ((k * span) / d + lo) & 255;
    endfunction

    function void note_item(logic [MW-1:0] m, logic [KW-1:0] code);
      gradient_word_t w;
      int d, best, n;
      w = '0;
      unique case (m)
        ncg_pkg::MODE_CLEAR: codes.delete();
        ncg_pkg::MODE_LOAD: begin
          if (codes.size() < STORE_ENTRIES) codes.push_back(code);
          else w.ovf = 1'b1;
          want_q.push_back(w);
        end
        ncg_pkg::MODE_QUERY: begin
          d = int'(depth_reg);
          if (d < 1) d = 1;
          if (d > MAX_DIGITS) d = MAX_DIGITS;
          best = d;
          foreach (codes[i]) begin
            if (best != 0) begin
              n = 0;
              for (int j = 0; j < d && j < ncg_pkg::CODE_DIGITS; j++)
                if (codes[i][2*j +: 2] != code[2*j +: 2]) n++;
              if (n < best) best = n;
            end
          end
          w.ndiff = DW'(best);
          w.red   = CW'(shade(start_rgb[0], end_rgb[0], best, d));
          w.green = CW'(shade(start_rgb[1], end_rgb[1], best, d));
          w.blue  = CW'(shade(start_rgb[2], end_rgb[2], best, d));
          want_q.push_back(w);
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(gradient_word_t got);
      gradient_word_t w;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        return;
      end
      w = want_q.pop_front();
      compare("digit_distance", CW'(w.ndiff), CW'(got.ndiff));
      compare("red_out", w.red, got.red);
      compare("green_out", w.green, got.green);
      compare("blue_out", w.blue, got.blue);
      compare("store_overflow", CW'(w.ovf), CW'(got.ovf));
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          start     = 1'b0;
  logic [MW-1:0] mode      = ncg_pkg::MODE_CLEAR;
  logic [KW-1:0] path_code = '0;
  logic          cfg_we    = 1'b0;
  logic [IW-1:0] cfg_addr  = ncg_pkg::REG_CODE_DEPTH;
  logic [VW-1:0] cfg_wdata = '0;
  logic          busy;
  logic          done;
  logic [DW-1:0] digit_distance;
  logic [CW-1:0] red_out;
  logic [CW-1:0] green_out;
  logic [CW-1:0] blue_out;
  logic          store_overflow;

  gradient_scoreboard board = new();

  int burst_left  = 0;
  int sent        = 0;
  int idle_cycles = 0;

  nearest_code_gradient_colour #(
    .MAX_DIGITS(MAX_DIGITS),
    .STORE_ENTRIES(STORE_ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .path_code(path_code),
    .done(done),
    .digit_distance(digit_distance),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .store_overflow(store_overflow),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_item(mode, path_code);
      if (done)
        board.check_result({digit_distance, red_out, green_out, blue_out, store_overflow});
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [KW-1:0] mutate(logic [KW-1:0] code, int flips);
    int pos;
    for (int i = 0; i < flips; i++) begin
      pos = $urandom_range(0, ncg_pkg::CODE_DIGITS - 1);
      code[2*pos +: 2] = code[2*pos +: 2] ^ 2'($urandom_range(1, 3));
    end
    return code;
  endfunction

  task automatic send(logic [MW-1:0] m, logic [KW-1:0] code);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(20, 80);
      else gap = $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) begin
          mode      <= 2'($urandom);
          path_code <= $urandom;
          @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (m != MODE_UNUSED) sent++;
    start     <= 1'b1;
    mode      <= m;
    path_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [7:0] depth, sr, sg, sb, er, eg, eb);
    write_reg(ncg_pkg::REG_CODE_DEPTH, depth);
    write_reg(ncg_pkg::REG_START_RED, sr);
    write_reg(ncg_pkg::REG_START_GREEN, sg);
    write_reg(ncg_pkg::REG_START_BLUE, sb);
    write_reg(ncg_pkg::REG_END_RED, er);
    write_reg(ncg_pkg::REG_END_GREEN, eg);
    write_reg(ncg_pkg::REG_END_BLUE, eb);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce(int hold);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0 || busy) @(posedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic run_sequence(int max_loads);
    logic [KW-1:0] base;
    int n;
    base = $urandom;
    if ($urandom_range(0, 4) == 0) send(ncg_pkg::MODE_CLEAR, $urandom);
    n = $urandom_range(0, max_loads);
    repeat (n)
      send(ncg_pkg::MODE_LOAD, ($urandom_range(0, 3) == 0) ? $urandom
                                   : mutate(base, $urandom_range(0, 6)));
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: send(ncg_pkg::MODE_QUERY, $urandom);
        1: send(MODE_UNUSED, $urandom);
        2: send(ncg_pkg::MODE_CLEAR, $urandom);
        default: send(ncg_pkg::MODE_QUERY, mutate(base, $urandom_range(0, 5)));
      endcase
    end
  endtask

  initial begin
    logic [KW-1:0] base;
    logic [KW-1:0] last;
    int target;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(ncg_pkg::MODE_QUERY, 32'h0000_0000);
    send(ncg_pkg::MODE_LOAD, 32'h0000_0000);
    send(ncg_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    send(ncg_pkg::MODE_LOAD, 32'hAAAA_AAAA);
    send(ncg_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    send(ncg_pkg::MODE_QUERY, 32'h5555_5555);
    send(ncg_pkg::MODE_QUERY, 32'hFFF0_0000);
    send(ncg_pkg::MODE_QUERY, 32'h0000_0FFF);
    send(MODE_UNUSED, 32'hDEAD_BEEF);
    send(ncg_pkg::MODE_CLEAR, 32'h1234_5678);
    send(ncg_pkg::MODE_QUERY, 32'h1234_5678);
    send(ncg_pkg::MODE_LOAD, 32'h1234_5678);
    quiesce(8);
    apply_setting(8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(ncg_pkg::MODE_QUERY, 32'h1234_5679);
    send(ncg_pkg::MODE_QUERY, 32'h1234_5678);
    send(ncg_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    quiesce(8);
    apply_setting(8'hFF, 8'd0, 8'd128, 8'd255, 8'd255, 8'd128, 8'd0);
    send(ncg_pkg::MODE_QUERY, 32'h1234_5678);
    send(ncg_pkg::MODE_QUERY, 32'hEDCB_A987);
    send(ncg_pkg::MODE_QUERY, 32'h1234_5670);
    send(ncg_pkg::MODE_LOAD, 32'h0000_0000);
    send(ncg_pkg::MODE_QUERY, 32'h0000_0003);
    quiesce(8);
    apply_setting(8'd16, 8'd7, 8'd200, 8'd90, 8'd250, 8'd3, 8'd90);
    send(ncg_pkg::MODE_QUERY, 32'hC000_0000);
    send(ncg_pkg::MODE_QUERY, 32'h8000_0001);

    for (int p = 0; p < PHASES; p++) begin
      quiesce(8);
      case (p)
        0: apply_setting(8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        1: apply_setting(8'd16, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        2: apply_setting(8'($urandom_range(1, 16)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      target = sent + PHASE_WORDS;
      while (sent < target) run_sequence((p == 3) ? 60 : 8);
    end

    quiesce(8);
    apply_setting(8'd5, 8'd10, 8'd200, 8'd77, 8'd250, 8'd3, 8'd77);
    send(ncg_pkg::MODE_CLEAR, $urandom);
    base = $urandom;
    last = base;
    repeat (FINAL_LOADS) begin
      last = mutate(base, $urandom_range(1, 5));
      send(ncg_pkg::MODE_LOAD, last);
    end
    send(ncg_pkg::MODE_QUERY, base);
    send(ncg_pkg::MODE_QUERY, ~base);
    send(ncg_pkg::MODE_QUERY, last);
    send(ncg_pkg::MODE_CLEAR, $urandom);
    send(ncg_pkg::MODE_QUERY, base);

    quiesce(60);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
